// File: rtl/core/mm_pkg.sv
// ----------------------------------------------------------------------------
// mm_pkg
// shared widths and codes for the fixed-point matrix multiply block
// ----------------------------------------------------------------------------
package mm_pkg;

  localparam int KIND_W    = 2;
  localparam int IDX_W     = 4;   // row and column fields
  localparam int VALUE_W   = 16;  // signed q8.8 element
  localparam int PROD_W    = 32;  // signed q16.16 product
  localparam int SUM_W     = 40;  // signed q24.16 sum
  localparam int DIM_W     = 5;   // dimension registers
  localparam int CFG_IDX_W = 2;
  localparam int IDX_CAP   = 16;  // largest dimension the index fields can reach

  // item kinds
  localparam logic [KIND_W-1:0] KIND_WR_A = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WR_B = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ROW  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_M_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_K_INNER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_N_COLS  = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

endpackage

// File: rtl/core/mm_in_if.sv
// ----------------------------------------------------------------------------
// mm_in_if
// input channel: element loads and row requests
// ----------------------------------------------------------------------------
interface mm_in_if;
  import mm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic [IDX_W-1:0]          row;
  logic [IDX_W-1:0]          col;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, kind, row, col, value, input ready);
  modport sink   (input valid, kind, row, col, value, output ready);

endinterface

// File: rtl/core/mm_out_if.sv
// ----------------------------------------------------------------------------
// mm_out_if
// output channel: one result element per beat
// ----------------------------------------------------------------------------
interface mm_out_if;
  import mm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        out_row;
  logic [IDX_W-1:0]        out_col;
  logic signed [SUM_W-1:0] sum;
  logic                    last;

  modport source (output valid, out_row, out_col, sum, last, input ready);
  modport sink   (input valid, out_row, out_col, sum, last, output ready);

endinterface

// File: rtl/core/matrix_multiply.sv
// ----------------------------------------------------------------------------
// matrix_multiply
// fixed-point c = a x b with element loads and row-at-a-time readout
// ----------------------------------------------------------------------------
// A and B live in two synchronous rams of MAX_DIM x MAX_DIM signed q8.8
// entries, addressed row * MAX_DIM + col. A load beat (kind write A or
// write B) writes its entry; loads outside the store are dropped. A row
// request for a row below the effective m_rows emits effective n_cols
// beats in column order, the last one flagged, each the exact q24.16 dot
// product in 40 bits. One shared multiply-accumulate walks k for each
// column over the two ram read ports, through the ram read, the product
// register and the accumulator; the next column starts only once the
// finished sum has moved to the output register, so an undrained output
// stalls the request. Loads and requests are taken only between requests.
// The output register lets a finished beat wait while the next item is
// accepted. Dimension registers are clamped to [1, min(MAX_DIM, 16)].
// Entries are undefined until written; reads and writes never overlap
// because writes are only taken between requests.
// ----------------------------------------------------------------------------
module matrix_multiply #(
  parameter int MAX_DIM = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mm_pkg::DIM_W-1:0]       cfg_data,
  mm_in_if.sink                          in_ch,
  mm_out_if.source                       out_ch
);
  import mm_pkg::*;

  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int AW      = $clog2(DEPTH);
  localparam int DIM_CAP = (MAX_DIM < IDX_CAP) ? MAX_DIM : IDX_CAP;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN} state_t;

  // dimension registers
  logic [DIM_W-1:0] m_rows, k_inner, n_cols;
  logic [DIM_W-1:0] m_eff, k_eff, n_eff;

  // sequencer
  state_t           state;
  logic [IDX_W-1:0] row_q;   // requested row
  logic [IDX_W-1:0] k;       // inner index
  logic [IDX_W-1:0] j;       // result column

  // datapath pipeline
  logic                      rd_v, rd_first, rd_last;
  logic                      p_v, p_first, p_last;
  logic signed [PROD_W-1:0]  prod;
  logic signed [SUM_W-1:0]   acc;
  logic                      sum_ready;

  // output register
  logic                    out_valid;
  logic [IDX_W-1:0]        out_row_q, out_col_q;
  logic signed [SUM_W-1:0] sum_q;
  logic                    last_q;

  // ram ports
  logic                we_a, we_b;
  logic [AW-1:0]       waddr, raddr_a, raddr_b;
  logic [VALUE_W-1:0]  rdata_a, rdata_b;

  logic accept, in_store, start, issue, issue_last, col_last, load;

  // clamp a dimension register to its usable range
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] raw);
    logic [DIM_W-1:0] r;
    if (raw == '0) begin
      r = DIM_W'(1);
    end else if (int'(raw) > DIM_CAP) begin
      r = DIM_W'(DIM_CAP);
    end else begin
      r = raw;
    end
    return r;
  endfunction

  assign m_eff = eff_dim(m_rows);
  assign k_eff = eff_dim(k_inner);
  assign n_eff = eff_dim(n_cols);

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (rst) begin
      m_rows  <= DIM_RESET;
      k_inner <= DIM_RESET;
      n_cols  <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_M_ROWS:  m_rows  <= cfg_data;
        CFG_K_INNER: k_inner <= cfg_data;
        CFG_N_COLS:  n_cols  <= cfg_data;
        default: ;   // no register at this index
      endcase
    end
  end

  // ---- input decode ----
  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_store    = (int'(in_ch.row) < MAX_DIM) && (int'(in_ch.col) < MAX_DIM);
  assign waddr       = AW'(AW'(in_ch.row) * AW'(MAX_DIM) + AW'(in_ch.col));

  always_comb begin
    we_a  = 1'b0;
    we_b  = 1'b0;
    start = 1'b0;
    unique case (in_ch.kind)
      KIND_WR_A: we_a  = accept && in_store;
      KIND_WR_B: we_b  = accept && in_store;
      KIND_ROW:  start = accept && ({1'b0, in_ch.row} < m_eff);
      default: ;   // unused kind, dropped
    endcase
  end

  // ---- stores ----
  // a is read along its row, b down its column
  assign raddr_a = AW'(AW'(row_q) * AW'(MAX_DIM) + AW'(k));
  assign raddr_b = AW'(AW'(k) * AW'(MAX_DIM) + AW'(j));

  mm_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_a_store (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (in_ch.value),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  mm_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_b_store (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (in_ch.value),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  // ---- sequencer ----
  assign issue      = (state == S_RUN);
  assign issue_last = ({1'b0, k} == k_eff - DIM_W'(1));
  assign col_last   = ({1'b0, j} == n_eff - DIM_W'(1));
  // finished sum moves to the output register once it is free
  assign load       = (state == S_DRAIN) && sum_ready && (!out_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      sum_ready <= 1'b0;
      rd_v      <= 1'b0;
      p_v       <= 1'b0;
    end else begin
      rd_v <= issue;
      p_v  <= rd_v;

      if (p_v && p_last) begin
        sum_ready <= 1'b1;
      end

      if (out_ch.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            row_q <= in_ch.row;
            k     <= '0;
            j     <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (issue_last) begin
            k     <= '0;
            state <= S_DRAIN;
          end else begin
            k <= k + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          if (load) begin
            sum_ready <= 1'b0;
            out_valid <= 1'b1;
            out_row_q <= row_q;
            out_col_q <= j;
            sum_q     <= acc;
            last_q    <= col_last;
            if (col_last) begin
              state <= S_IDLE;
            end else begin
              j     <= j + IDX_W'(1);
              state <= S_RUN;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---- multiply-accumulate ----
  // issue -> ram read -> product register -> accumulator
  always_ff @(posedge clk) begin
    rd_first <= issue && (k == '0);
    rd_last  <= issue && issue_last;
    p_first  <= rd_first;
    p_last   <= rd_last;
    prod     <= $signed(rdata_a) * $signed(rdata_b);
    if (p_v) begin
      acc <= (p_first ? '0 : acc) + SUM_W'(prod);
    end
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.out_row = out_row_q;
  assign out_ch.out_col = out_col_q;
  assign out_ch.sum     = sum_q;
  assign out_ch.last    = last_q;

  // ---- checks ----
  // ram data only comes back for reads the sequencer issued
  a_rd_from_run: assert property (@(posedge clk) disable iff (rst)
    rd_v |-> $past(state == S_RUN))
    else $error("read data without an issued read");

  // a finished sum must leave before the next column accumulates
  a_sum_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(sum_ready && p_v))
    else $error("accumulator overrun by next column");

  // an in-range row request starts the inner loop
  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    start |=> (state == S_RUN) && (k == '0) && (j == '0))
    else $error("row request did not start");

  // stores are written only between requests
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    (we_a || we_b) |-> !rd_v && !p_v && !sum_ready)
    else $error("store written during a request");

endmodule

// File: rtl/core/mm_ram.sv
// ----------------------------------------------------------------------------
// mm_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
